// ===== src/complex_arithmetic_unit_macros.svh =====
// assertion macros for the complex arithmetic unit
`ifndef COMPLEX_ARITHMETIC_UNIT_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define CAU_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> cons) \
		else $error(msg);
`define CAU_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);
`else
`define CAU_ASSERT_IMP(lbl, ante, cons, msg)
`define CAU_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ===== src/cau_pkg.sv =====
// shared types, codes and helpers of the complex arithmetic unit
package cau_pkg;

	localparam int CAU_FRAC_BITS = 28;
	// quotient bits produced, one per divider stage (value * 2 before rounding)
	localparam int CAU_QBITS = 34;
	// square root digits, one per stage in the last stages of the divider row
	localparam int CAU_ROOT_BITS = 32;

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_MUL = 3'd1;
	localparam logic [2:0] OP_DIV = 3'd2;
	localparam logic [2:0] OP_MOD = 3'd3;
	localparam logic [2:0] OP_EQ  = 3'd4;

	typedef struct packed {
		logic [2:0]         op;
		logic signed [31:0] a_re;
		logic signed [31:0] a_im;
		logic signed [31:0] b_re;
		logic signed [31:0] b_im;
	} cau_in_t;

	typedef struct packed {
		logic signed [31:0] res_re;
		logic signed [31:0] res_im;
		logic               is_equal;
		logic               div_by_zero;
		logic               overflowed;
	} cau_out_t;

	typedef struct packed {
		logic        ovf;
		logic [31:0] val;
	} cau_sat_t;

	// working state of one item in the divider / square root row
	typedef struct packed {
		logic [2:0]   op;
		logic         neg_re;
		logic         neg_im;
		logic         dz;
		logic         qovf_re;
		logic         qovf_im;
		logic [63:0]  den;
		logic [63:0]  mag_re;
		logic [63:0]  mag_im;
		logic [63:0]  rem_re;
		logic [63:0]  rem_im;
		logic [CAU_QBITS-1:0] quo_re;
		logic [CAU_QBITS-1:0] quo_im;
		logic [34:0]  srem;
		logic [CAU_ROOT_BITS-1:0] root;
		cau_out_t     res;
	} cau_stage_t;

	// sign and magnitude to 32-bit two's complement with saturation
	function automatic cau_sat_t cau_clamp(input logic neg, input logic [64:0] mag);
		cau_sat_t s;
		if (neg) begin
			s.ovf = mag > 65'h0_8000_0000;
			s.val = s.ovf ? 32'h8000_0000 : 32'd0 - mag[31:0];
		end else begin
			s.ovf = mag > 65'h0_7FFF_FFFF;
			s.val = s.ovf ? 32'h7FFF_FFFF : mag[31:0];
		end
		return s;
	endfunction

	function automatic logic [32:0] cau_abs33(input logic signed [32:0] v);
		logic signed [32:0] n;
		n = -v;
		return v[32] ? n : v;
	endfunction

endpackage

// ===== src/cau_front.sv =====
// front stages: products, sums, magnitudes and divider setup
module cau_front import cau_pkg::*; #(
	parameter int FRAC_BITS = CAU_FRAC_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  cau_in_t     in_item,
	input  logic [30:0] tol,
	output logic        out_valid,
	output cau_stage_t  st_out
);

	localparam int RSHIFT = CAU_QBITS - 1 - FRAC_BITS;
	localparam logic [64:0] HALF = 65'(1) << (FRAC_BITS - 1);

	// stage 1
	logic               v_s1, v_s2, v_s3, v_s4;
	logic [2:0]         op_s1, op_s2, op_s3;
	logic signed [31:0] sq_x, sq_y;
	logic signed [63:0] ac_s1, bd_s1, ad_s1, bc_s1, sx_s1, sy_s1;
	logic signed [32:0] sre_s1, sim_s1;

	// stage 2
	logic signed [64:0] sum_re_s2, sum_im_s2;
	logic [63:0]        den_s2, den_s3;
	cau_out_t           res_s2, res_s3;
	cau_out_t           res_n;
	logic [32:0]        dre_abs, dim_abs;
	cau_sat_t           add_re, add_im;

	// stage 3
	logic               neg_re_s3, neg_im_s3, dz_s3;
	logic [63:0]        mag_re_s3, mag_im_s3;
	logic signed [64:0] nre, nim;

	// stage 4
	logic [64:0]        scl_re, scl_im;
	cau_sat_t           mul_re, mul_im;
	logic [63:0]        rin_re, rin_im;
	cau_stage_t         st_n, st_s4;

	always_comb begin
		sq_x = (in_item.op == OP_MOD) ? in_item.a_re : in_item.b_re;
		sq_y = (in_item.op == OP_MOD) ? in_item.a_im : in_item.b_im;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		op_s1 <= in_item.op;
		ac_s1 <= in_item.a_re * in_item.b_re;
		bd_s1 <= in_item.a_im * in_item.b_im;
		ad_s1 <= in_item.a_re * in_item.b_im;
		bc_s1 <= in_item.a_im * in_item.b_re;
		sx_s1 <= sq_x * sq_x;
		sy_s1 <= sq_y * sq_y;
		if (in_item.op == OP_EQ) begin
			sre_s1 <= 33'(in_item.a_re) - 33'(in_item.b_re);
			sim_s1 <= 33'(in_item.a_im) - 33'(in_item.b_im);
		end else begin
			sre_s1 <= 33'(in_item.a_re) + 33'(in_item.b_re);
			sim_s1 <= 33'(in_item.a_im) + 33'(in_item.b_im);
		end
	end

	// add and equality finish here
	always_comb begin
		dre_abs = cau_abs33(sre_s1);
		dim_abs = cau_abs33(sim_s1);
		add_re  = cau_clamp(sre_s1[32], 65'(dre_abs));
		add_im  = cau_clamp(sim_s1[32], 65'(dim_abs));
		res_n   = '0;
		case (op_s1)
			OP_ADD: begin
				res_n.res_re     = add_re.val;
				res_n.res_im     = add_im.val;
				res_n.overflowed = add_re.ovf | add_im.ovf;
			end
			OP_EQ: begin
				res_n.is_equal = (dre_abs <= 33'(tol)) && (dim_abs <= 33'(tol));
			end
			default: begin
				res_n = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		op_s2  <= op_s1;
		res_s2 <= res_n;
		den_s2 <= $unsigned(sx_s1) + $unsigned(sy_s1);
		if (op_s1 == OP_MUL) begin
			sum_re_s2 <= 65'(ac_s1) - 65'(bd_s1);
			sum_im_s2 <= 65'(ad_s1) + 65'(bc_s1);
		end else begin
			sum_re_s2 <= 65'(ac_s1) + 65'(bd_s1);
			sum_im_s2 <= 65'(bc_s1) - 65'(ad_s1);
		end
	end

	always_comb begin
		nre = -sum_re_s2;
		nim = -sum_im_s2;
	end

	always_ff @(posedge clk) begin
		op_s3     <= op_s2;
		res_s3    <= res_s2;
		den_s3    <= den_s2;
		dz_s3     <= den_s2 == 64'd0;
		neg_re_s3 <= sum_re_s2[64];
		neg_im_s3 <= sum_im_s2[64];
		mag_re_s3 <= sum_re_s2[64] ? nre[63:0] : sum_re_s2[63:0];
		mag_im_s3 <= sum_im_s2[64] ? nim[63:0] : sum_im_s2[63:0];
	end

	// multiply rounding, divider initial remainder and range check
	always_comb begin
		scl_re = (65'(mag_re_s3) + HALF) >> FRAC_BITS;
		scl_im = (65'(mag_im_s3) + HALF) >> FRAC_BITS;
		mul_re = cau_clamp(neg_re_s3, scl_re);
		mul_im = cau_clamp(neg_im_s3, scl_im);
		rin_re = mag_re_s3 >> RSHIFT;
		rin_im = mag_im_s3 >> RSHIFT;

		st_n         = '0;
		st_n.op      = op_s3;
		st_n.neg_re  = neg_re_s3;
		st_n.neg_im  = neg_im_s3;
		st_n.dz      = dz_s3;
		st_n.den     = den_s3;
		st_n.mag_re  = mag_re_s3;
		st_n.mag_im  = mag_im_s3;
		st_n.rem_re  = rin_re;
		st_n.rem_im  = rin_im;
		st_n.qovf_re = rin_re >= den_s3;
		st_n.qovf_im = rin_im >= den_s3;
		st_n.res     = res_s3;
		if (op_s3 == OP_MUL) begin
			st_n.res.res_re     = mul_re.val;
			st_n.res.res_im     = mul_im.val;
			st_n.res.overflowed = mul_re.ovf | mul_im.ovf;
		end
	end

	always_ff @(posedge clk) begin
		st_s4 <= st_n;
	end

	assign out_valid = v_s4;
	assign st_out    = st_s4;

endmodule

// ===== src/cau_div_step.sv =====
// one divider stage: a quotient bit for each part and, in the last stages of the row, a square root digit
module cau_div_step import cau_pkg::*; #(
	parameter int FRAC_BITS = CAU_FRAC_BITS,
	parameter int K         = 0
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  cau_stage_t st_in,
	output logic       out_valid,
	output cau_stage_t st_out
);

	localparam bit HAS_BIT = K > FRAC_BITS;
	localparam int BIT     = HAS_BIT ? K - FRAC_BITS - 1 : 0;

	logic        nb_re, nb_im, ge_re, ge_im;
	logic [64:0] t_re, t_im, d_re, d_im, den_x;
	logic [34:0] srem_n;
	logic [CAU_ROOT_BITS-1:0] root_n;
	cau_stage_t  st_n, st_q;
	logic        v_q;

	if (K < CAU_ROOT_BITS) begin : g_sqrt
		logic [34:0] st_t, st_trial;
		logic        st_ge;
		always_comb begin
			st_t     = {st_in.srem[32:0], st_in.den[2*K+1 -: 2]};
			st_trial = {1'b0, st_in.root, 2'b01};
			st_ge    = st_t >= st_trial;
			srem_n   = st_ge ? st_t - st_trial : st_t;
			root_n   = {st_in.root[CAU_ROOT_BITS-2:0], st_ge};
		end
	end else begin : g_pass
		assign srem_n = st_in.srem;
		assign root_n = st_in.root;
	end

	always_comb begin
		nb_re = HAS_BIT ? st_in.mag_re[BIT] : 1'b0;
		nb_im = HAS_BIT ? st_in.mag_im[BIT] : 1'b0;
		den_x = {1'b0, st_in.den};
		t_re  = {st_in.rem_re, nb_re};
		t_im  = {st_in.rem_im, nb_im};
		d_re  = t_re - den_x;
		d_im  = t_im - den_x;
		ge_re = t_re >= den_x;
		ge_im = t_im >= den_x;

		st_n        = st_in;
		st_n.rem_re = ge_re ? d_re[63:0] : t_re[63:0];
		st_n.rem_im = ge_im ? d_im[63:0] : t_im[63:0];
		st_n.quo_re = {st_in.quo_re[CAU_QBITS-2:0], ge_re};
		st_n.quo_im = {st_in.quo_im[CAU_QBITS-2:0], ge_im};
		st_n.srem   = srem_n;
		st_n.root   = root_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		st_q <= st_n;
	end

	assign out_valid = v_q;
	assign st_out    = st_q;

endmodule

// ===== src/cau_back.sv =====
// last stage: quotient and root rounding, saturation, result select
module cau_back import cau_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  cau_stage_t st_in,
	output logic       done,
	output cau_out_t   result
);

	localparam logic [64:0] BIG = 65'(1) << 40;

	logic [CAU_QBITS:0]   inc_re, inc_im;
	logic [CAU_QBITS-1:0] rnd_re, rnd_im;
	logic [32:0]          sq;
	cau_sat_t             q_re, q_im, s_mod;
	cau_out_t             res_n, res_q;
	logic                 done_q;

	always_comb begin
		inc_re = ((CAU_QBITS + 1)'(st_in.quo_re) + (CAU_QBITS + 1)'(1)) >> 1;
		inc_im = ((CAU_QBITS + 1)'(st_in.quo_im) + (CAU_QBITS + 1)'(1)) >> 1;
		rnd_re = inc_re[CAU_QBITS-1:0];
		rnd_im = inc_im[CAU_QBITS-1:0];
		q_re   = cau_clamp(st_in.neg_re, st_in.qovf_re ? BIG : 65'(rnd_re));
		q_im   = cau_clamp(st_in.neg_im, st_in.qovf_im ? BIG : 65'(rnd_im));
		sq     = 33'(st_in.root) + 33'(st_in.srem > 35'(st_in.root));
		s_mod  = cau_clamp(1'b0, 65'(sq));

		res_n = '0;
		case (st_in.op)
			OP_ADD, OP_MUL, OP_EQ: begin
				res_n = st_in.res;
			end
			OP_DIV: begin
				if (st_in.dz) begin
					res_n.div_by_zero = 1'b1;
				end else begin
					res_n.res_re     = q_re.val;
					res_n.res_im     = q_im.val;
					res_n.overflowed = q_re.ovf | q_im.ovf;
				end
			end
			OP_MOD: begin
				res_n.res_re     = s_mod.val;
				res_n.overflowed = s_mod.ovf;
			end
			default: begin
				res_n = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_n;
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

// ===== src/complex_arithmetic_unit.sv =====
// complex arithmetic unit top level: tolerance register and the full pipeline
// pipeline from start to done: 4 front stages, 34 divider stages, 1 output
// throughput: one item per cycle for every opcode; busy is always low
// the divider row is pipelined, one quotient bit per part in each stage
// reset clears all valid bits and the tolerance; items in flight are dropped
`include "complex_arithmetic_unit_macros.svh"
module complex_arithmetic_unit import cau_pkg::*; #(
	parameter int FRAC_BITS = CAU_FRAC_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  cau_in_t     operands,
	output logic        done,
	output cau_out_t    result,
	input  logic        cfg_we,
	input  logic [30:0] cfg_wdata
);

	// front stages plus divider row plus output register
	localparam int LAT = 4 + CAU_QBITS + 1;

	logic [30:0] tol_q;
	logic        acc;

	// valid bit and item state at each point of the divider row
	logic [CAU_QBITS:0] v_row;
	cau_stage_t         st_row [CAU_QBITS+1];

	// the pipeline never stalls, so an item is taken whenever start is high
	assign busy = 1'b0;
	assign acc  = start & ~busy;

	// tolerance for the equality test; the user must write it only while idle, the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= '0;
		end else if (cfg_we) begin
			tol_q <= cfg_wdata;
		end
	end

	// products, sums, add and equality results, divider setup
	cau_front #(
		.FRAC_BITS(FRAC_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (acc),
		.in_item  (operands),
		.tol      (tol_q),
		.out_valid(v_row[0]),
		.st_out   (st_row[0])
	);

	// restoring divider row, quotient bits from msb down; square root digits
	// ride along in the last stages
	for (genvar g = 0; g < CAU_QBITS; g++) begin : g_step
		cau_div_step #(
			.FRAC_BITS(FRAC_BITS),
			.K        (CAU_QBITS - 1 - g)
		) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (v_row[g]),
			.st_in    (st_row[g]),
			.out_valid(v_row[g+1]),
			.st_out   (st_row[g+1])
		);
	end

	// rounding, saturation and opcode select
	cau_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(v_row[CAU_QBITS]),
		.st_in   (st_row[CAU_QBITS]),
		.done    (done),
		.result  (result)
	);

	// fixed latency in both directions
	`CAU_ASSERT_IMP(a_lat_fwd, acc, ##LAT done, "accepted item did not complete on time")
	`CAU_ASSERT_IMP(a_lat_back, done, $past(acc, LAT), "result without a matching item")
	// divide by zero never reports saturation or equality
	`CAU_ASSERT_NEVER(a_dz_flags, done && result.div_by_zero && (result.overflowed || result.is_equal), "divide by zero with other flags")
	// equality results carry zero parts
	`CAU_ASSERT_IMP(a_eq_zero, done && result.is_equal, (result.res_re == 32'sd0 && result.res_im == 32'sd0), "equality result with nonzero parts")

endmodule

// ===== dv/tb_complex_arithmetic_unit.sv =====
// testbench for the complex arithmetic unit: random and directed items checked against a predictor
`timescale 1ns / 100ps
module tb_complex_arithmetic_unit;
	import cau_pkg::*;

	localparam int FRAC = CAU_FRAC_BITS;
	// margin after the last result comes back, to let the pipe drain
	localparam int DRAIN_CYCLES = 60;
	// cycles with no item taken in or given out before the run is declared hung
	localparam int STALL_LIMIT = 5000;
	localparam logic [30:0] TOL_MAX = 31'h7FFF_FFFF;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	cau_in_t     operands = '0;
	logic        done;
	cau_out_t    result;
	logic        cfg_we = 1'b0;
	logic [30:0] cfg_wdata = '0;

	complex_arithmetic_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.operands  (operands),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// items waiting to be sent, and results the block still owes us
	cau_in_t  send_q[$];
	cau_out_t owed_q[$];
	logic [30:0] tol_copy = '0;
	int mismatches = 0;
	bit no_gaps = 1'b0;

	// ---------------- predictor ----------------

	// sign and magnitude of a two-product sum held modulo 2^64
	function automatic bit [63:0] to_sign_mag(input bit [63:0] u, output bit neg);
		neg = u[63] && (u != 64'h8000_0000_0000_0000);
		return neg ? 64'd0 - u : u;
	endfunction

	// clamp a signed magnitude into 32 bits, flagging saturation
	function automatic bit [31:0] saturate(input bit neg, input bit [63:0] mag, inout bit ovf);
		if (neg) begin
			if (mag > 64'h8000_0000) begin
				ovf = 1'b1;
				return 32'h8000_0000;
			end
			return 32'd0 - mag[31:0];
		end
		if (mag > 64'h7FFF_FFFF) begin
			ovf = 1'b1;
			return 32'h7FFF_FFFF;
		end
		return mag[31:0];
	endfunction

	// rounded quotient mag * 2^FRAC / den, ties away from zero
	function automatic bit [63:0] quotient_rounded(input bit [63:0] mag, input bit [63:0] den);
		bit [63:0] q, r;
		q = mag / den;
		r = mag % den;
		if (q > 64'h1_0000_0000) return 64'h100_0000_0000;
		for (int i = 0; i < FRAC; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= den) begin
				r = r - den;
				q[0] = 1'b1;
			end
		end
		r = r << 1;
		if (r >= den) q = q + 1;
		return q;
	endfunction

	// integer square root, rounded to nearest
	function automatic bit [63:0] root_rounded(input bit [63:0] s);
		bit [63:0] root, bitpos;
		root = 0;
		bitpos = 64'd1 << 62;
		while (bitpos > s) bitpos = bitpos >> 2;
		while (bitpos != 0) begin
			if (s >= root + bitpos) begin
				s = s - (root + bitpos);
				root = (root >> 1) + bitpos;
			end else begin
				root = root >> 1;
			end
			bitpos = bitpos >> 2;
		end
		if (s > root) root = root + 1;
		return root;
	endfunction

	function automatic cau_out_t complex_result(input cau_in_t it, input logic [30:0] tol);
		cau_out_t o;
		longint a, b, c, d, s1, s2;
		bit [63:0] mag, den, m1, m2;
		bit neg, ovf;
		o = '0;
		ovf = 1'b0;
		a = longint'(it.a_re);
		b = longint'(it.a_im);
		c = longint'(it.b_re);
		d = longint'(it.b_im);
		case (it.op)
			OP_ADD: begin
				s1 = a + c;
				s2 = b + d;
				o.res_re = saturate(s1 < 0, s1 < 0 ? -s1 : s1, ovf);
				o.res_im = saturate(s2 < 0, s2 < 0 ? -s2 : s2, ovf);
			end
			OP_MUL: begin
				// products carry twice the fraction bits; round back down
				mag = to_sign_mag(64'(a * c) - 64'(b * d), neg);
				o.res_re = saturate(neg, (mag + (64'd1 << (FRAC - 1))) >> FRAC, ovf);
				mag = to_sign_mag(64'(a * d) + 64'(b * c), neg);
				o.res_im = saturate(neg, (mag + (64'd1 << (FRAC - 1))) >> FRAC, ovf);
			end
			OP_DIV: begin
				den = 64'(c * c) + 64'(d * d);
				if (den == 0) begin
					o.div_by_zero = 1'b1;
				end else begin
					mag = to_sign_mag(64'(a * c) + 64'(b * d), neg);
					o.res_re = saturate(neg, quotient_rounded(mag, den), ovf);
					mag = to_sign_mag(64'(b * c) - 64'(a * d), neg);
					o.res_im = saturate(neg, quotient_rounded(mag, den), ovf);
				end
			end
			OP_MOD: begin
				o.res_re = saturate(1'b0, root_rounded(64'(a * a) + 64'(b * b)), ovf);
			end
			OP_EQ: begin
				s1 = a - c;
				s2 = b - d;
				m1 = s1 < 0 ? -s1 : s1;
				m2 = s2 < 0 ? -s2 : s2;
				o.is_equal = (m1 <= tol) && (m2 <= tol);
			end
			default: ;
		endcase
		o.overflowed = ovf;
		return o;
	endfunction

	// ---------------- stimulus helpers ----------------

	// operand part: full range, values near unity, tiny values, or extremes
	function automatic logic [31:0] pick_part();
		int mode;
		mode = $urandom_range(0, 9);
		case (mode)
			0, 1, 2: return $urandom;
			3, 4, 5: return 32'($signed($urandom_range(0, 32'h3FFF_FFFF)) - 32'sh2000_0000);
			6: return 32'($signed($urandom_range(0, 2047)) - 1024);
			default: begin
				case ($urandom_range(0, 4))
					0: return 32'h0000_0000;
					1: return 32'h0000_0001;
					2: return 32'hFFFF_FFFF;
					3: return 32'h7FFF_FFFF;
					default: return 32'h8000_0000;
				endcase
			end
		endcase
	endfunction

	function automatic cau_in_t random_item();
		cau_in_t it;
		it.op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
		it.a_re = pick_part();
		it.a_im = pick_part();
		it.b_re = pick_part();
		it.b_im = pick_part();
		// equality is only interesting when the operands sit close together
		if (it.op == OP_EQ && $urandom_range(0, 2) != 0) begin
			it.b_re = it.a_re + 32'($signed($urandom_range(0, 64)) - 32);
			it.b_im = it.a_im + 32'($signed($urandom_range(0, 64)) - 32);
		end
		if (it.op == OP_DIV && $urandom_range(0, 24) == 0) begin
			it.b_re = '0;
			it.b_im = '0;
		end
		return it;
	endfunction

	function automatic cau_in_t make_item(logic [2:0] op, logic [31:0] ar, logic [31:0] ai,
	                                      logic [31:0] br, logic [31:0] bi);
		cau_in_t it;
		it.op = op;
		it.a_re = ar;
		it.a_im = ai;
		it.b_re = br;
		it.b_im = bi;
		return it;
	endfunction

	// gap before the next item: mostly none or short, now and then long
	function automatic int next_gap();
		int r;
		if (no_gaps) return 0;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
		mismatches++;
	endtask

	// ---------------- driver ----------------
	int gap_left = 0;
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			// item taken at this edge: record what the block owes
			if (start && !busy) owed_q.push_back(complex_result(operands, tol_copy));
			if (start && busy) begin
				// hold the item until the block takes it
			end else if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (send_q.size() != 0) begin
				operands <= send_q.pop_front();
				start <= 1'b1;
				gap_left = next_gap();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// ---------------- monitor ----------------
	always @(posedge clk) begin
		cau_out_t want;
		if (arst_n && done) begin
			if (owed_q.size() == 0) begin
				$display("unexpected result at %0t: %h", $realtime, result);
				mismatches++;
			end else begin
				want = owed_q.pop_front();
				if (result.res_re !== want.res_re) report("res_re", result.res_re, want.res_re);
				if (result.res_im !== want.res_im) report("res_im", result.res_im, want.res_im);
				if (result.is_equal !== want.is_equal)
					report("is_equal", 32'(result.is_equal), 32'(want.is_equal));
				if (result.div_by_zero !== want.div_by_zero)
					report("div_by_zero", 32'(result.div_by_zero), 32'(want.div_by_zero));
				if (result.overflowed !== want.overflowed)
					report("overflowed", 32'(result.overflowed), 32'(want.overflowed));
			end
		end
	end

	// ---------------- watchdog ----------------
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((start && !busy) || done) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("complex_arithmetic_unit verification failed");
			$finish;
		end
	end

	// ---------------- sequencing ----------------

	// hold off until everything sent has come back, then let the pipe drain
	task automatic drain();
		while (send_q.size() != 0 || start || owed_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_tolerance(input logic [30:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		tol_copy = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_phase(input int n);
		// first half, then a full pause until all results are in, then the rest
		for (int i = 0; i < n / 2; i++) send_q.push_back(random_item());
		while (send_q.size() != 0 || start || owed_q.size() != 0) @(posedge clk);
		for (int i = n / 2; i < n; i++) send_q.push_back(random_item());
		drain();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset tolerance is zero, so equality is exact here
		send_q.push_back(make_item(OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
		send_q.push_back(make_item(OP_ADD, 32'h1000_0000, 32'hF000_0000, 32'h0000_0001, 32'hFFFF_FFFF));
		send_q.push_back(make_item(OP_MUL, 32'h1000_0000, 32'h0000_0000, 32'h1000_0000, 32'h1000_0000));
		send_q.push_back(make_item(OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
		send_q.push_back(make_item(OP_MUL, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		send_q.push_back(make_item(OP_MUL, 32'h0000_0001, 32'h0000_0000, 32'h0800_0000, 32'h0000_0000));
		send_q.push_back(make_item(OP_DIV, 32'h1000_0000, 32'h1000_0000, 32'h0000_0000, 32'h0000_0000));
		send_q.push_back(make_item(OP_DIV, 32'h1000_0000, 32'h0000_0000, 32'h2000_0000, 32'h0000_0000));
		send_q.push_back(make_item(OP_DIV, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001, 32'h0000_0000));
		send_q.push_back(make_item(OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
		send_q.push_back(make_item(OP_DIV, 32'h0000_0001, 32'hFFFF_FFFF, 32'h3000_0000, 32'hD000_0000));
		send_q.push_back(make_item(OP_MOD, 32'h3000_0000, 32'h4000_0000, 32'h0, 32'h0));
		send_q.push_back(make_item(OP_MOD, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0));
		send_q.push_back(make_item(OP_MOD, 32'h0000_0000, 32'h0000_0000, 32'h0, 32'h0));
		send_q.push_back(make_item(OP_MOD, 32'h0000_0001, 32'h0000_0001, 32'h0, 32'h0));
		send_q.push_back(make_item(OP_EQ, 32'h1234_5678, 32'h8000_0000, 32'h1234_5678, 32'h8000_0000));
		send_q.push_back(make_item(OP_EQ, 32'h1234_5678, 32'h0000_0000, 32'h1234_5679, 32'h0000_0000));
		send_q.push_back(make_item(OP_EQ, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
		send_q.push_back(make_item(3'd5, 32'h1, 32'h2, 32'h3, 32'h4));
		send_q.push_back(make_item(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send_q.push_back(make_item(3'd7, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h1));
		drain();

		// largest tolerance: the widest difference still fails equality
		write_tolerance(TOL_MAX);
		send_q.push_back(make_item(OP_EQ, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h0));
		send_q.push_back(make_item(OP_EQ, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0));
		random_phase(280);

		// back-to-back items with a small tolerance
		write_tolerance(31'd16);
		no_gaps = 1'b1;
		random_phase(280);
		no_gaps = 1'b0;

		write_tolerance(31'($urandom));
		random_phase(280);

		write_tolerance('0);
		random_phase(280);

		if (mismatches == 0) begin
			$display("complex_arithmetic_unit verification clean");
		end else begin
			$display("complex_arithmetic_unit verification failed");
		end
		$finish;
	end

endmodule
